### rtl/mqtt_rx_packet_deframer_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef MQTT_RX_PACKET_DEFRAMER_MACROS_SVH
`define MQTT_RX_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MRD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MRD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/mqttrx_pkg.sv
// Types, codes and helpers for the MQTT receive deframer.
package mqttrx_pkg;

   localparam int LEN_W     = 28;
   localparam int TOPIC_W   = 16;
   localparam int BYTE_W    = 8;

   localparam logic [2:0] HDR_LAST = 3'd4;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_BODY    = 2'd1,
      KIND_DISCARD = 2'd2
   } byte_kind_type;

   typedef enum logic [2:0] {
      PT_CONNACK     = 3'd0,
      PT_PUBLISH     = 3'd1,
      PT_PUBACK      = 3'd2,
      PT_SUBACK      = 3'd3,
      PT_UNSUBACK    = 3'd4,
      PT_PINGRESP    = 3'd5,
      PT_UNSUPPORTED = 3'd6
   } packet_type_type;

   typedef enum logic [2:0] {
      ROLE_TOPIC_LEN = 3'd0,
      ROLE_TOPIC     = 3'd1,
      ROLE_PKT_ID    = 3'd2,
      ROLE_DATA      = 3'd3,
      ROLE_OTHER     = 3'd4
   } body_role_type;

   // Command nibbles (byte bits 7..4)
   localparam logic [3:0] CMD_CONNACK  = 4'h2;
   localparam logic [3:0] CMD_PUBLISH  = 4'h3;
   localparam logic [3:0] CMD_PUBACK   = 4'h4;
   localparam logic [3:0] CMD_SUBACK   = 4'h9;
   localparam logic [3:0] CMD_UNSUBACK = 4'hB;
   localparam logic [3:0] CMD_PINGRESP = 4'hD;

   localparam logic [1:0] QOS_ONE = 2'd1;

   function automatic packet_type_type classify(input logic [BYTE_W-1:0] cmd);
      packet_type_type pt;
      case (cmd[7:4])
         CMD_CONNACK:  pt = PT_CONNACK;
         CMD_PUBLISH:  pt = PT_PUBLISH;
         CMD_PUBACK:   pt = PT_PUBACK;
         CMD_SUBACK:   pt = PT_SUBACK;
         CMD_UNSUBACK: pt = PT_UNSUBACK;
         CMD_PINGRESP: pt = PT_PINGRESP;
         default:      pt = PT_UNSUPPORTED;
      endcase
      return pt;
   endfunction

endpackage

### rtl/mqtt_rx_packet_deframer.sv
// MQTT receive deframer: fixed header decode and body byte tagging.
//
// Usage: one received byte enters per request on the req_ channel
// (req_valid / req_stall / req_rx_byte). Every byte yields exactly one
// result on the rsp_ channel: its kind (header, body, discarded header),
// packet type and QoS of the command byte held, its role inside a PUBLISH
// body, end-of-packet flag, the decoded remaining length, topic length,
// packet id and an acknowledge flag at the end of a QoS-1 publish.
// Flow: a byte accepted into the input register moves on into the result
// register (rsp_valid high) once that register is free or drains. Throughput:
// one byte per cycle while rsp_stall is low; the state update is a short
// add/compare path between the input register and the result register.
// Stall: while rsp_stall holds a result, one more byte is still taken into
// the input register; only then does req_stall rise.
// Reset (synchronous, active high) clears both stages and returns the
// framer to hunting for a command byte with all packet registers zero.
// A header whose fourth length byte still has its continuation bit set is
// dropped (kind discard) and the next byte is taken as a command byte.
`include "mqtt_rx_packet_deframer_macros.svh"

module mqtt_rx_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_byte_kind,
   output logic [2:0]  rsp_packet_type,
   output logic [1:0]  rsp_qos_level,
   output logic [7:0]  rsp_data_byte,
   output logic [2:0]  rsp_body_role,
   output logic        rsp_packet_end,
   output logic [27:0] rsp_body_length,
   output logic [15:0] rsp_topic_length,
   output logic [15:0] rsp_packet_id,
   output logic        rsp_ack_request
);

   localparam int LW = mqttrx_pkg::LEN_W;
   localparam int TW = mqttrx_pkg::TOPIC_W;
   localparam int BW = mqttrx_pkg::BYTE_W;

   // Handshake / stage control
   logic          s1_valid_ff, s1_valid_in;
   logic [BW-1:0] s1_byte_ff;
   logic          out_valid_ff, out_valid_in;
   logic          req_take, advance;

   // Framer state
   logic          in_body_ff, in_body_in;
   logic [2:0]    hdr_cnt_ff, hdr_cnt_in;
   logic [BW-1:0] cmd_ff, cmd_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] body_cnt_ff, body_cnt_in;
   logic [TW-1:0] topic_len_ff, topic_len_in;
   logic [TW-1:0] pid_ff, pid_in;

   // Result of the current byte
   mqttrx_pkg::byte_kind_type   kind;
   mqttrx_pkg::body_role_type   role;
   mqttrx_pkg::packet_type_type ptype;
   logic                        pkt_end;
   logic                        ack;
   logic [LW-1:0]               len_part;
   logic [LW-1:0]               len_acc;
   logic [LW-1:0]               topic_end;
   logic [LW-1:0]               pid_end;

   // Result register
   mqttrx_pkg::byte_kind_type   kind_ff;
   mqttrx_pkg::body_role_type   role_ff;
   mqttrx_pkg::packet_type_type ptype_ff;
   logic [1:0]    qos_ff;
   logic [BW-1:0] data_ff;
   logic          end_ff, ack_ff;
   logic [LW-1:0] out_len_ff;
   logic [TW-1:0] out_topic_ff, out_pid_ff;

   // ---------------------------------------------------------------
   // Handshake: the result register drains when not stalled; the input
   // register advances whenever the result register can take a new value.
   // ---------------------------------------------------------------
   assign advance     = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign req_take    = req_valid && !req_stall;
   assign s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in = advance ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);

   // Place the 7-bit length group of this header byte by its position.
   always_comb begin
      case (hdr_cnt_ff)
         3'd1:    len_part = {21'd0, s1_byte_ff[6:0]};
         3'd2:    len_part = {14'd0, s1_byte_ff[6:0], 7'd0};
         3'd3:    len_part = {7'd0, s1_byte_ff[6:0], 14'd0};
         default: len_part = {s1_byte_ff[6:0], 21'd0};
      endcase
   end

   assign len_acc   = len_ff | len_part;
   assign topic_end = {{(LW-TW){1'b0}}, topic_len_ff} + LW'(2);
   assign pid_end   = {{(LW-TW){1'b0}}, topic_len_ff} + LW'(4);

   // ---------------------------------------------------------------
   // Framer next state and per-byte result.
   // ---------------------------------------------------------------
   always_comb begin
      in_body_in   = in_body_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      cmd_in       = cmd_ff;
      len_in       = len_ff;
      body_cnt_in  = body_cnt_ff;
      topic_len_in = topic_len_ff;
      pid_in       = pid_ff;
      kind         = mqttrx_pkg::KIND_HEADER;
      role         = mqttrx_pkg::ROLE_TOPIC_LEN;
      pkt_end      = 1'b0;

      if (!in_body_ff) begin
         if (hdr_cnt_ff == 3'd0) begin
            // Command byte: open a new packet
            cmd_in       = s1_byte_ff;
            hdr_cnt_in   = 3'd1;
            len_in       = '0;
            body_cnt_in  = '0;
            topic_len_in = '0;
            pid_in       = '0;
         end else if (hdr_cnt_ff > mqttrx_pkg::HDR_LAST) begin
            kind       = mqttrx_pkg::KIND_DISCARD;
            hdr_cnt_in = 3'd0;
            len_in     = '0;
         end else begin
            len_in = len_acc;
            if (!s1_byte_ff[7]) begin
               // Last length byte: empty packets end here
               hdr_cnt_in = 3'd0;
               if (len_acc == '0) begin
                  pkt_end = 1'b1;
               end else begin
                  in_body_in  = 1'b1;
                  body_cnt_in = '0;
               end
            end else if (hdr_cnt_ff == mqttrx_pkg::HDR_LAST) begin
               // Length still continues after four bytes: drop the header
               kind       = mqttrx_pkg::KIND_DISCARD;
               hdr_cnt_in = 3'd0;
               len_in     = '0;
            end else begin
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
            end
         end
      end else begin
         kind = mqttrx_pkg::KIND_BODY;
         if (mqttrx_pkg::classify(cmd_ff) != mqttrx_pkg::PT_PUBLISH) begin
            role = mqttrx_pkg::ROLE_OTHER;
         end else if (body_cnt_ff < LW'(2)) begin
            role = mqttrx_pkg::ROLE_TOPIC_LEN;
            if (body_cnt_ff == '0) begin
               topic_len_in = {s1_byte_ff, topic_len_ff[7:0]};
            end else begin
               topic_len_in = {topic_len_ff[15:8], s1_byte_ff};
            end
         end else if (body_cnt_ff < topic_end) begin
            role = mqttrx_pkg::ROLE_TOPIC;
         end else if (cmd_ff[2:1] == mqttrx_pkg::QOS_ONE && body_cnt_ff < pid_end) begin
            role = mqttrx_pkg::ROLE_PKT_ID;
            if (body_cnt_ff == topic_end) begin
               pid_in = {s1_byte_ff, pid_ff[7:0]};
            end else begin
               pid_in = {pid_ff[15:8], s1_byte_ff};
            end
         end else begin
            role = mqttrx_pkg::ROLE_DATA;
         end
         body_cnt_in = body_cnt_ff + LW'(1);
         if (body_cnt_in == len_ff) begin
            pkt_end    = 1'b1;
            in_body_in = 1'b0;
            hdr_cnt_in = 3'd0;
         end
      end
   end

   assign ptype = mqttrx_pkg::classify(cmd_in);
   assign ack   = pkt_end && ptype == mqttrx_pkg::PT_PUBLISH
                  && cmd_in[2:1] == mqttrx_pkg::QOS_ONE;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         in_body_ff   <= 1'b0;
         hdr_cnt_ff   <= 3'd0;
         cmd_ff       <= '0;
         len_ff       <= '0;
         body_cnt_ff  <= '0;
         topic_len_ff <= '0;
         pid_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            in_body_ff   <= in_body_in;
            hdr_cnt_ff   <= hdr_cnt_in;
            cmd_ff       <= cmd_in;
            len_ff       <= len_in;
            body_cnt_ff  <= body_cnt_in;
            topic_len_ff <= topic_len_in;
            pid_ff       <= pid_in;
         end
      end
   end

   // Payload registers: load the input byte on accept, the result on advance
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         kind_ff      <= kind;
         role_ff      <= role;
         ptype_ff     <= ptype;
         qos_ff       <= cmd_in[2:1];
         data_ff      <= s1_byte_ff;
         end_ff       <= pkt_end;
         ack_ff       <= ack;
         out_len_ff   <= len_in;
         out_topic_ff <= topic_len_in;
         out_pid_ff   <= pid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_byte_kind    = kind_ff;
   assign rsp_packet_type  = ptype_ff;
   assign rsp_qos_level    = qos_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_body_role    = role_ff;
   assign rsp_packet_end   = end_ff;
   assign rsp_body_length  = out_len_ff;
   assign rsp_topic_length = out_topic_ff;
   assign rsp_packet_id    = out_pid_ff;
   assign rsp_ack_request  = ack_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `MRD_ASSERT_IMP(a_ack_at_publish_end, clock, reset,
      out_valid_ff && ack_ff,
      end_ff && ptype_ff == mqttrx_pkg::PT_PUBLISH && qos_ff == mqttrx_pkg::QOS_ONE,
      "acknowledge request outside the end of a QoS-1 publish")
   `MRD_ASSERT_IMP(a_discard_no_end, clock, reset,
      out_valid_ff && kind_ff == mqttrx_pkg::KIND_DISCARD,
      !end_ff && !in_body_ff,
      "discarded header reported a packet end")
   `MRD_ASSERT_NXT(a_input_reg_hold, clock, reset,
      s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_byte_ff) && $stable(cmd_ff),
      "held input byte or framer state changed while blocked")

endmodule

### tb/mqtt_deframe_checker.sv
// Tag checker for the MQTT receive deframer: predicts each byte's tag and compares results.
`timescale 1ns / 100ps

module mqtt_deframe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_byte_kind,
   input  logic [2:0]  rsp_packet_type,
   input  logic [1:0]  rsp_qos_level,
   input  logic [7:0]  rsp_data_byte,
   input  logic [2:0]  rsp_body_role,
   input  logic        rsp_packet_end,
   input  logic [27:0] rsp_body_length,
   input  logic [15:0] rsp_topic_length,
   input  logic [15:0] rsp_packet_id,
   input  logic        rsp_ack_request,
   output int          fail_count,
   output int          tags_pending
);

   typedef struct packed {
      mqttrx_pkg::byte_kind_type   kind;
      mqttrx_pkg::packet_type_type ptype;
      logic [1:0]                  qos;
      logic [7:0]                  data;
      mqttrx_pkg::body_role_type   role;
      logic                        pend;
      logic [27:0]                 blen;
      logic [15:0]                 tlen;
      logic [15:0]                 pid;
      logic                        ack;
   } byte_tag_type;

   byte_tag_type tags_due [$];
   int           mismatches = 0;

   // framer state as the block should hold it
   logic        in_body;
   logic [2:0]  hdr_count;
   logic [7:0]  cmd;
   logic [27:0] len_accum;
   logic [27:0] body_count;
   logic [15:0] topic_len;
   logic [15:0] pkt_id;

   function automatic mqttrx_pkg::packet_type_type type_of_command(input logic [7:0] c);
      case (c[7:4])
         mqttrx_pkg::CMD_CONNACK:  return mqttrx_pkg::PT_CONNACK;
         mqttrx_pkg::CMD_PUBLISH:  return mqttrx_pkg::PT_PUBLISH;
         mqttrx_pkg::CMD_PUBACK:   return mqttrx_pkg::PT_PUBACK;
         mqttrx_pkg::CMD_SUBACK:   return mqttrx_pkg::PT_SUBACK;
         mqttrx_pkg::CMD_UNSUBACK: return mqttrx_pkg::PT_UNSUBACK;
         mqttrx_pkg::CMD_PINGRESP: return mqttrx_pkg::PT_PINGRESP;
         default:                  return mqttrx_pkg::PT_UNSUPPORTED;
      endcase
   endfunction

   // Advance the framer by one byte and return the tag it should carry.
   function automatic byte_tag_type deframe_byte(input logic [7:0] b);
      byte_tag_type              t;
      mqttrx_pkg::byte_kind_type kind;
      mqttrx_pkg::body_role_type role;
      logic                      pend;
      logic [31:0]               pos;
      logic [31:0]               topic_end;
      kind = mqttrx_pkg::KIND_HEADER;
      role = mqttrx_pkg::ROLE_TOPIC_LEN;
      pend = 1'b0;
      if (!in_body) begin
         if (hdr_count == 3'd0) begin
            cmd        = b;
            hdr_count  = 3'd1;
            len_accum  = '0;
            body_count = '0;
            topic_len  = '0;
            pkt_id     = '0;
         end else if (hdr_count > mqttrx_pkg::HDR_LAST) begin
            kind      = mqttrx_pkg::KIND_DISCARD;
            hdr_count = 3'd0;
            len_accum = '0;
         end else begin
            len_accum = len_accum | (28'(b[6:0]) << (7 * (hdr_count - 3'd1)));
            if (!b[7]) begin
               hdr_count = 3'd0;
               if (len_accum == '0) begin
                  pend = 1'b1;
               end else begin
                  in_body    = 1'b1;
                  body_count = '0;
               end
            end else if (hdr_count == mqttrx_pkg::HDR_LAST) begin
               kind      = mqttrx_pkg::KIND_DISCARD;
               hdr_count = 3'd0;
               len_accum = '0;
            end else begin
               hdr_count = hdr_count + 3'd1;
            end
         end
      end else begin
         kind      = mqttrx_pkg::KIND_BODY;
         pos       = 32'(body_count);
         topic_end = 32'd2 + 32'(topic_len);
         if (type_of_command(cmd) != mqttrx_pkg::PT_PUBLISH) begin
            role = mqttrx_pkg::ROLE_OTHER;
         end else if (pos < 32'd2) begin
            role = mqttrx_pkg::ROLE_TOPIC_LEN;
            if (pos == 32'd0) topic_len[15:8] = b;
            else topic_len[7:0] = b;
         end else if (pos < topic_end) begin
            role = mqttrx_pkg::ROLE_TOPIC;
         end else if (cmd[2:1] == mqttrx_pkg::QOS_ONE && pos < topic_end + 32'd2) begin
            role = mqttrx_pkg::ROLE_PKT_ID;
            if (pos == topic_end) pkt_id[15:8] = b;
            else pkt_id[7:0] = b;
         end else begin
            role = mqttrx_pkg::ROLE_DATA;
         end
         body_count = body_count + 28'd1;
         if (body_count == len_accum) begin
            pend      = 1'b1;
            in_body   = 1'b0;
            hdr_count = 3'd0;
         end
      end
      t.kind  = kind;
      t.ptype = type_of_command(cmd);
      t.qos   = cmd[2:1];
      t.data  = b;
      t.role  = role;
      t.pend  = pend;
      t.blen  = len_accum;
      t.tlen  = topic_len;
      t.pid   = pkt_id;
      t.ack   = pend && t.ptype == mqttrx_pkg::PT_PUBLISH && cmd[2:1] == mqttrx_pkg::QOS_ONE;
      return t;
   endfunction

   function automatic int field_mismatch(input string name, input int unsigned want,
                                         input int unsigned seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      byte_tag_type due;
      if (reset) begin
         in_body    = 1'b0;
         hdr_count  = 3'd0;
         cmd        = '0;
         len_accum  = '0;
         body_count = '0;
         topic_len  = '0;
         pkt_id     = '0;
         tags_due.delete();
      end else begin
         if (req_valid && !req_stall)
            tags_due.push_back(deframe_byte(req_rx_byte));
         if (rsp_valid && !rsp_stall) begin
            if (tags_due.size() == 0) begin
               $error("result arrived with no byte outstanding");
               mismatches++;
            end else begin
               due = tags_due.pop_front();
               mismatches += field_mismatch("byte_kind", due.kind, rsp_byte_kind);
               mismatches += field_mismatch("packet_type", due.ptype, rsp_packet_type);
               mismatches += field_mismatch("qos_level", due.qos, rsp_qos_level);
               mismatches += field_mismatch("data_byte", due.data, rsp_data_byte);
               mismatches += field_mismatch("body_role", due.role, rsp_body_role);
               mismatches += field_mismatch("packet_end", due.pend, rsp_packet_end);
               mismatches += field_mismatch("body_length", due.blen, rsp_body_length);
               mismatches += field_mismatch("topic_length", due.tlen, rsp_topic_length);
               mismatches += field_mismatch("packet_id", due.pid, rsp_packet_id);
               mismatches += field_mismatch("ack_request", due.ack, rsp_ack_request);
            end
         end
      end
      fail_count   <= mismatches;
      tags_pending <= tags_due.size();
   end

endmodule

### tb/tb_mqtt_rx_packet_deframer.sv
// Testbench top for the MQTT receive deframer: byte stream stimulus, idling phases, verdict.
`timescale 1ns / 100ps

module tb_mqtt_rx_packet_deframer;

   // Generous ceiling: about 1800 bytes, each with its worst-case gap and stall.
   localparam int unsigned CYCLE_LIMIT = 200000;
   // Random bytes per idling phase, four phases in all.
   localparam int unsigned PHASE_BYTES = 440;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_byte_kind;
   logic [2:0]  rsp_packet_type;
   logic [1:0]  rsp_qos_level;
   logic [7:0]  rsp_data_byte;
   logic [2:0]  rsp_body_role;
   logic        rsp_packet_end;
   logic [27:0] rsp_body_length;
   logic [15:0] rsp_topic_length;
   logic [15:0] rsp_packet_id;
   logic        rsp_ack_request;

   int          fail_count;
   int          tags_pending;
   int unsigned cycle_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;

   // Bytes waiting to be offered on the request channel.
   logic [7:0]  byte_stream [$];

   // Opening stream: connack, pingresp and publish packets, zero-length endings and broken headers.
   logic [7:0]  opening [26] = '{
      // connack with empty body
      8'h20, 8'h00,
      // pingresp whose zero length spans a redundant continuation byte
      8'hD0, 8'h80, 8'h00,
      // QoS-1 publish with no body: acknowledge with packet id zero
      8'h32, 8'h00,
      // four length bytes all continuing: header dropped
      8'hB0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      // full QoS-1 publish, topic of two bytes, id 0x1234, one data byte
      8'h32, 8'h07, 8'h00, 8'h02, 8'h61, 8'h62, 8'h12, 8'h34, 8'h55,
      // QoS-1 publish that ends inside its topic
      8'h33, 8'h03, 8'h00, 8'h05, 8'h41
   };

   mqtt_rx_packet_deframer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_packet_type  (rsp_packet_type),
      .rsp_qos_level    (rsp_qos_level),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_body_role    (rsp_body_role),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_body_length  (rsp_body_length),
      .rsp_topic_length (rsp_topic_length),
      .rsp_packet_id    (rsp_packet_id),
      .rsp_ack_request  (rsp_ack_request)
   );

   mqtt_deframe_checker tag_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_kind    (rsp_byte_kind),
      .rsp_packet_type  (rsp_packet_type),
      .rsp_qos_level    (rsp_qos_level),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_body_role    (rsp_body_role),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_body_length  (rsp_body_length),
      .rsp_topic_length (rsp_topic_length),
      .rsp_packet_id    (rsp_packet_id),
      .rsp_ack_request  (rsp_ack_request),
      .fail_count       (fail_count),
      .tags_pending     (tags_pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stall the result channel at random, at the rate the current phase sets.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Abandon the run if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Offer one request and hold it until the block takes it. Idle cycles come first,
   // so a gap can fall anywhere in the stream.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      // taken at the first edge where stall was low
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_stream();
      while (byte_stream.size() != 0)
         send_byte(byte_stream.pop_front());
   endtask

   // Hold the sender off until every outstanding request has produced its result.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tags_pending != 0) @(posedge clock);
   endtask

   // Encode a remaining length, least significant group first; now and then pad it
   // with redundant zero groups so that three- and four-byte headers turn up.
   task automatic push_length(input int unsigned value);
      int unsigned rest;
      logic [7:0]  grp;
      int          n;
      rest = value;
      n    = 0;
      do begin
         grp  = {1'b0, rest[6:0]};
         rest = rest >> 7;
         if (rest != 0) grp[7] = 1'b1;
         byte_stream.push_back(grp);
         n++;
      end while (rest != 0);
      while (n < 4 && $urandom_range(9) == 0) begin
         byte_stream[byte_stream.size() - 1] = byte_stream[byte_stream.size() - 1] | 8'h80;
         byte_stream.push_back(8'h00);
         n++;
      end
   endtask

   // Publish with random topic, id and data. Now and then break it: a topic length
   // that disagrees with the body, or a body cut short.
   task automatic queue_publish();
      logic [7:0]  cmd;
      logic [15:0] claimed;
      int unsigned tlen;
      int unsigned dlen;
      int unsigned blen;
      logic [7:0]  body [$];
      cmd      = 8'($urandom);
      cmd[7:4] = mqttrx_pkg::CMD_PUBLISH;
      if ($urandom_range(1)) cmd[2:1] = mqttrx_pkg::QOS_ONE;
      tlen    = $urandom_range(0, 6);
      dlen    = $urandom_range(0, 8);
      claimed = 16'(tlen);
      if ($urandom_range(9) == 0) claimed = 16'($urandom);
      body.push_back(claimed[15:8]);
      body.push_back(claimed[7:0]);
      for (int i = 0; i < tlen; i++) body.push_back(8'($urandom));
      if (cmd[2:1] == mqttrx_pkg::QOS_ONE) begin
         body.push_back(8'($urandom));
         body.push_back(8'($urandom));
      end
      for (int i = 0; i < dlen; i++) body.push_back(8'($urandom));
      blen = body.size();
      if ($urandom_range(9) == 0) blen = $urandom_range(0, blen);
      byte_stream.push_back(cmd);
      push_length(blen);
      for (int i = 0; i < blen; i++) byte_stream.push_back(body[i]);
   endtask

   // Any other packet: a known non-publish type, or a random command byte as noise.
   task automatic queue_other(input logic any_cmd);
      logic [7:0]  cmd;
      int unsigned blen;
      cmd = 8'($urandom);
      if (!any_cmd) begin
         case ($urandom_range(0, 5))
            0:       cmd[7:4] = mqttrx_pkg::CMD_CONNACK;
            1:       cmd[7:4] = mqttrx_pkg::CMD_PUBACK;
            2:       cmd[7:4] = mqttrx_pkg::CMD_SUBACK;
            3:       cmd[7:4] = mqttrx_pkg::CMD_UNSUBACK;
            4:       cmd[7:4] = mqttrx_pkg::CMD_PINGRESP;
            default: cmd[7:4] = 4'($urandom);
         endcase
      end
      // mostly short bodies; a few long enough to need two length bytes
      if ($urandom_range(9) == 0) blen = $urandom_range(0, 300);
      else blen = $urandom_range(0, 12);
      byte_stream.push_back(cmd);
      push_length(blen);
      for (int i = 0; i < blen; i++) byte_stream.push_back(8'($urandom));
   endtask

   // Header whose four length bytes all continue: the block must drop it.
   task automatic queue_dropped_header();
      byte_stream.push_back(8'($urandom));
      repeat (4) byte_stream.push_back(8'h80 | 8'($urandom));
   endtask

   task automatic run_random(input int unsigned n_bytes);
      int unsigned sent;
      int          pick;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(99);
         if (pick < 50) queue_publish();
         else if (pick < 75) queue_other(1'b0);
         else if (pick < 85) queue_dropped_header();
         else queue_other(1'b1);
         sent += byte_stream.size();
         send_stream();
      end
   endtask

   initial begin
      // Hold reset, then release it at an edge.
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // No idling on either side: opening stream, then random packets.
      foreach (opening[i]) byte_stream.push_back(opening[i]);
      send_stream();
      run_random(PHASE_BYTES);
      drain();

      // Sender idle most of the time.
      idle_pct = 60;
      run_random(PHASE_BYTES);
      drain();

      // Receiver stalling most of the time.
      idle_pct = 0;
      stall_pct <= 60;
      run_random(PHASE_BYTES);
      drain();

      // Both sides idling now and then.
      idle_pct = 25;
      stall_pct <= 25;
      run_random(PHASE_BYTES);
      drain();

      // Let the two-stage pipeline settle before the verdict.
      repeat (8) @(posedge clock);
      if (fail_count == 0 && tags_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
